FILE: rtl/rwcl_pkg.sv
// Shared types and constants for the RIFF/WAVE chunk locator.
`default_nettype none

package rwcl_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int OFFSET_W = 33;
    localparam int SIZE_W   = 32;

    localparam logic [31:0] MIN_FORMAT_LENGTH = 32'd14;

    // Little-endian chunk tags as assembled from the byte stream
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [SIZE_W-1:0]   size_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_RIFF  = 3'd1,
        ST_NOT_WAVE  = 3'd2,
        ST_FMT_SHORT = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_TRUNCATED = 3'd5
    } status_t;

    typedef enum logic [5:0] {
        PH_TAG   = 6'b000001,
        PH_RLEN  = 6'b000010,
        PH_FORM  = 6'b000100,
        PH_CTAG  = 6'b001000,
        PH_CLEN  = 6'b010000,
        PH_SKIP  = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_FMT   = 2'd1,
        KIND_DATA  = 2'd2
    } kind_t;

    localparam logic CFG_WANT_FORMAT = 1'b0;
    localparam logic CFG_WANT_DATA   = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/rwcl_byte_if.sv
// Byte request channel: one file byte and the last-byte flag.
`default_nettype none

interface rwcl_byte_if;
    import rwcl_pkg::*;

    logic  valid;
    logic  ready;
    byte_t file_byte;
    logic  last_byte;

    modport source (output valid, output file_byte, output last_byte, input ready);
    modport sink   (input valid, input file_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/rwcl_result_if.sv
// Result request channel: status and the located chunk positions.
`default_nettype none

interface rwcl_result_if;
    import rwcl_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    offset_t format_offset;
    offset_t data_offset;
    size_t   data_size;

    modport source (output valid, output status, output format_offset,
                    output data_offset, output data_size, input ready);
    modport sink   (input valid, input status, input format_offset,
                    input data_offset, input data_size, output ready);
endinterface

`default_nettype wire

FILE: rtl/riff_wave_chunk_locator.sv
// Top level of the RIFF/WAVE chunk locator: byte walker and result register.
//
// channel      dir  payload                                           request
// file_chan    in   file_byte[7:0], last_byte                         one file byte
// result_chan  out  status[2:0], format_offset[32:0],                 one status
//                   data_offset[32:0], data_size[31:0]
// cfg_*        in   cfg_index[0], cfg_data[0]                         register write
//
// One byte per cycle: the walker state updates in the cycle a byte is taken, and the
// result lands in a single output register in the same cycle.
// A byte is taken whenever the output register is empty or being drained, so a
// stalled result blocks input only while it is still unclaimed.
// Reset (rst_n low, asynchronous) clears the walker; want_format/want_data reset to 1.
// A byte with last_byte set rearms the walker; configuration is kept.
`default_nettype none

module riff_wave_chunk_locator (
    input  wire logic clk,
    input  wire logic rst_n,
    rwcl_byte_if.sink     file_chan,
    rwcl_result_if.source result_chan,
    input  wire logic cfg_we,
    input  wire logic cfg_index,
    input  wire logic cfg_data
);
    import rwcl_pkg::*;

    logic    want_format_reg;
    logic    want_data_reg;

    phase_t  phase_reg, phase_next;
    offset_t pos_reg, pos_next;
    logic [31:0] word_reg, word_next;
    logic [1:0]  biw_reg, biw_next;
    kind_t   kind_reg, kind_next;
    offset_t skip_reg, skip_next;
    offset_t end_reg, end_next;
    logic    fmt_seen_reg, fmt_seen_next;
    logic    data_seen_reg, data_seen_next;
    offset_t held_fmt_reg, held_fmt_next;
    offset_t held_doff_reg, held_doff_next;
    size_t   held_dsize_reg, held_dsize_next;
    logic    finished_reg, finished_next;

    logic    out_valid_reg;
    status_t out_status_reg;
    offset_t out_fmt_reg;
    offset_t out_doff_reg;
    size_t   out_dsize_reg;

    logic    accept;
    logic    emit;
    status_t emit_status;
    offset_t emit_fmt;
    offset_t emit_doff;
    size_t   emit_dsize;

    logic [31:0] word_in;
    logic [33:0] body_off;
    logic [32:0] padded;
    logic [34:0] next_off;
    logic        chunk_done;

    assign file_chan.ready = !out_valid_reg || result_chan.ready;
    assign accept          = file_chan.valid && file_chan.ready;

    assign word_in  = {file_chan.file_byte, word_reg[31:8]};
    assign body_off = {1'b0, pos_reg} + 34'd1;
    // body length rounded up to even
    assign padded   = ({1'b0, word_in} + 33'd1) & ~33'd1;
    assign next_off = {1'b0, body_off} + {2'b00, padded};

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        word_next       = word_reg;
        biw_next        = biw_reg;
        kind_next       = kind_reg;
        skip_next       = skip_reg;
        end_next        = end_reg;
        fmt_seen_next   = fmt_seen_reg;
        data_seen_next  = data_seen_reg;
        held_fmt_next   = held_fmt_reg;
        held_doff_next  = held_doff_reg;
        held_dsize_next = held_dsize_reg;
        finished_next   = finished_reg;
        emit            = 1'b0;
        emit_status     = ST_FOUND;
        chunk_done      = 1'b0;

        if (accept && !finished_reg)
        begin
            pos_next = pos_reg + 33'd1;
            if (phase_reg == PH_SKIP)
            begin
                skip_next = skip_reg - 33'd1;
                if (skip_next == '0)
                begin
                    phase_next = PH_CTAG;
                end
            end
            else
            begin
                word_next = word_in;
                biw_next  = biw_reg + 2'd1;
                if (biw_reg == 2'd3)
                begin
                    case (phase_reg)
                        PH_TAG:
                        begin
                            if (word_in != TAG_RIFF)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_NOT_RIFF;
                            end
                            else
                            begin
                                phase_next = PH_RLEN;
                            end
                        end
                        PH_RLEN:
                        begin
                            end_next   = {1'b0, word_in} + 33'd8;
                            phase_next = PH_FORM;
                        end
                        PH_FORM:
                        begin
                            if (word_in != TAG_WAVE)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_NOT_WAVE;
                            end
                            else
                            begin
                                phase_next = PH_CTAG;
                            end
                        end
                        PH_CTAG:
                        begin
                            if (word_in == TAG_FMT)
                                kind_next = KIND_FMT;
                            else if (word_in == TAG_DATA)
                                kind_next = KIND_DATA;
                            else
                                kind_next = KIND_OTHER;
                            phase_next = PH_CLEN;
                        end
                        PH_CLEN:
                        begin
                            if (kind_reg == KIND_FMT && want_format_reg && !fmt_seen_reg)
                            begin
                                if (word_in < MIN_FORMAT_LENGTH)
                                begin
                                    emit        = 1'b1;
                                    emit_status = ST_FMT_SHORT;
                                    chunk_done  = 1'b1;
                                end
                                else
                                begin
                                    held_fmt_next = body_off[OFFSET_W-1:0];
                                    fmt_seen_next = 1'b1;
                                    if (!want_data_reg || data_seen_reg)
                                    begin
                                        emit        = 1'b1;
                                        emit_status = ST_FOUND;
                                        chunk_done  = 1'b1;
                                    end
                                end
                            end
                            else if (kind_reg == KIND_DATA && want_data_reg && !data_seen_reg)
                            begin
                                held_doff_next  = body_off[OFFSET_W-1:0];
                                held_dsize_next = word_in;
                                data_seen_next  = 1'b1;
                                if (!want_format_reg || fmt_seen_reg)
                                begin
                                    emit        = 1'b1;
                                    emit_status = ST_FOUND;
                                    chunk_done  = 1'b1;
                                end
                            end
                            if (!chunk_done)
                            begin
                                if (next_off >= {2'b00, end_reg})
                                begin
                                    emit        = 1'b1;
                                    emit_status = ST_NOT_FOUND;
                                end
                                else if (padded == '0)
                                begin
                                    phase_next = PH_CTAG;
                                end
                                else
                                begin
                                    skip_next  = padded;
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_TAG;
                        end
                    endcase
                end
            end
            if (!emit && file_chan.last_byte)
            begin
                emit        = 1'b1;
                emit_status = ST_TRUNCATED;
            end
            if (emit)
            begin
                finished_next = 1'b1;
            end
        end

        // result carries the held values after this byte's update
        emit_fmt   = held_fmt_next;
        emit_doff  = held_doff_next;
        emit_dsize = held_dsize_next;

        if (accept && file_chan.last_byte)
        begin
            phase_next      = PH_TAG;
            pos_next        = '0;
            word_next       = '0;
            biw_next        = '0;
            kind_next       = KIND_OTHER;
            skip_next       = '0;
            end_next        = '0;
            fmt_seen_next   = 1'b0;
            data_seen_next  = 1'b0;
            held_fmt_next   = '0;
            held_doff_next  = '0;
            held_dsize_next = '0;
            finished_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_format_reg <= 1'b1;
            want_data_reg   <= 1'b1;
            phase_reg       <= PH_TAG;
            pos_reg         <= '0;
            word_reg        <= '0;
            biw_reg         <= '0;
            kind_reg        <= KIND_OTHER;
            skip_reg        <= '0;
            end_reg         <= '0;
            fmt_seen_reg    <= 1'b0;
            data_seen_reg   <= 1'b0;
            held_fmt_reg    <= '0;
            held_doff_reg   <= '0;
            held_dsize_reg  <= '0;
            finished_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WANT_FORMAT)
                    want_format_reg <= cfg_data;
                else
                    want_data_reg <= cfg_data;
            end
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            word_reg       <= word_next;
            biw_reg        <= biw_next;
            kind_reg       <= kind_next;
            skip_reg       <= skip_next;
            end_reg        <= end_next;
            fmt_seen_reg   <= fmt_seen_next;
            data_seen_reg  <= data_seen_next;
            held_fmt_reg   <= held_fmt_next;
            held_doff_reg  <= held_doff_next;
            held_dsize_reg <= held_dsize_next;
            finished_reg   <= finished_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (result_chan.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_fmt_reg    <= emit_fmt;
            out_doff_reg   <= emit_doff;
            out_dsize_reg  <= emit_dsize;
        end
    end

    assign result_chan.valid         = out_valid_reg;
    assign result_chan.status        = out_status_reg;
    assign result_chan.format_offset = out_fmt_reg;
    assign result_chan.data_offset   = out_doff_reg;
    assign result_chan.data_size     = out_dsize_reg;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_chan.ready |-> !emit)
        else $error("pending result overwritten");

    // after a file's result, nothing more until the rearm
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !emit)
        else $error("second result for one file");

    // last byte always leaves the walker rearmed
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        accept && file_chan.last_byte |=> phase_reg == PH_TAG && pos_reg == '0
            && !finished_reg)
        else $error("walker not rearmed after last byte");

    // body skip never runs with an empty count
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != '0)
        else $error("skip phase with zero count");

endmodule

`default_nettype wire
